>>> hdl/ccm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccm_pkg;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [3:0] CLS_NONE    = 4'd0;
  localparam logic [3:0] CLS_SHORT   = 4'd1;
  localparam logic [3:0] CLS_NOTCFM  = 4'd2;
  localparam logic [3:0] CLS_BADCCM  = 4'd3;
  localparam logic [3:0] CLS_OWN     = 4'd4;
  localparam logic [3:0] CLS_LEARN   = 4'd5;
  localparam logic [3:0] CLS_CHANGE  = 4'd6;
  localparam logic [3:0] CLS_MATCH   = 4'd7;
  localparam logic [3:0] CLS_MEPMISS = 4'd8;
  localparam logic [3:0] CLS_UNKNOWN = 4'd9;

  localparam logic [2:0] REG_CCM_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_STARTUP     = 3'd1;
  localparam logic [2:0] REG_DOWN_CONF   = 3'd2;
  localparam logic [2:0] REG_UP_CONF     = 3'd3;
  localparam logic [2:0] REG_MD_LEVEL    = 3'd4;
  localparam logic [2:0] REG_ETHER_TYPE  = 3'd5;
  localparam logic [2:0] REG_OPCODE      = 3'd6;
  localparam logic [2:0] REG_GROUP_MAC   = 3'd7;

  localparam logic [11:0] SHORT_HDR_LEN = 12'd18;
  localparam logic [11:0] SHORT_CCM_LEN = 12'd24;
  localparam logic [12:0] MEP_MASK      = 13'h1FFF;
  localparam logic [3:0]  COUNT_MAX     = 4'd15;

  localparam int IN_W  = 248;
  localparam int OUT_W = 152;

  typedef struct packed {
    logic [15:0] ccm_timeout_ms;
    logic [15:0] startup_timeout_ms;
    logic [3:0]  down_confirm;
    logic [3:0]  up_confirm;
    logic [2:0]  md_level;
    logic [15:0] cfm_ether_type;
    logic [7:0]  ccm_opcode;
    logic [47:0] group_mac;
  } cfg_t;

  // pre-classified item passed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  link;
    logic        link_ok;
    logic [31:0] now_ms;
    logic [3:0]  pre_class;
    logic [47:0] mac;
    logic [15:0] mep_id;
    logic [47:0] self_addr;
  } item_t;

  function automatic logic [12:0] mep_hash(input logic [47:0] mac);
    logic [12:0] h;
    h = mac[12:0] & MEP_MASK;
    return (h == 13'd0) ? 13'd1 : h;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ccm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ccm_front #(
  parameter int NUM_LINKS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ccm_pkg::cfg_t            cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [ccm_pkg::IN_W-1:0] in_data,
  output logic                          q_valid,
  input  wire logic                     q_ready,
  output ccm_pkg::item_t                q_item
);

  ccm_pkg::item_t cur;
  logic [11:0] len;
  logic [15:0] et;
  logic [7:0]  lvl;
  logic [7:0]  op;
  logic        full0;
  logic        full1;
  logic        wr_ptr;
  logic        rd_ptr;
  ccm_pkg::item_t slot0;
  ccm_pkg::item_t slot1;

  assign len = in_data[48:37];
  assign et  = in_data[64:49];
  assign lvl = in_data[72:65];
  assign op  = in_data[80:73];

  always_comb begin
    cur.kind      = in_data[1:0];
    cur.link      = in_data[4:2];
    cur.link_ok   = ({29'd0, in_data[4:2]} < NUM_LINKS);
    cur.now_ms    = in_data[36:5];
    cur.mac       = (in_data[1:0] == ccm_pkg::KIND_INIT) ? in_data[240:193] : in_data[128:81];
    cur.mep_id    = in_data[144:129];
    cur.self_addr = in_data[192:145];
    if (len < ccm_pkg::SHORT_HDR_LEN) begin
      cur.pre_class = ccm_pkg::CLS_SHORT;
    end else if (et != cfg.cfm_ether_type) begin
      cur.pre_class = ccm_pkg::CLS_NOTCFM;
    end else if (len < ccm_pkg::SHORT_CCM_LEN) begin
      cur.pre_class = ccm_pkg::CLS_SHORT;
    end else if (lvl[7:5] != cfg.md_level || op != cfg.ccm_opcode) begin
      cur.pre_class = ccm_pkg::CLS_BADCCM;
    end else begin
      cur.pre_class = ccm_pkg::CLS_NONE;
    end
  end

  // two-entry queue
  assign in_ready = !(full0 && full1);
  assign q_valid  = rd_ptr ? full1 : full0;
  assign q_item   = rd_ptr ? slot1 : slot0;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (wr_ptr) begin
        slot1 <= cur;
      end else begin
        slot0 <= cur;
      end
    end
    if (rst) begin
      full0  <= 1'b0;
      full1  <= 1'b0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= !wr_ptr;
        if (wr_ptr) full1 <= 1'b1; else full0 <= 1'b1;
      end
      if (q_valid && q_ready) begin
        rd_ptr <= !rd_ptr;
        if (rd_ptr) full1 <= 1'b0; else full0 <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/ccm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ccm_back #(
  parameter int NUM_LINKS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ccm_pkg::cfg_t             cfg,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire ccm_pkg::item_t            q_item,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ccm_pkg::OUT_W-1:0]      out_data
);

  localparam int LW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

  logic [NUM_LINKS-1:0] link_valid;
  logic [NUM_LINKS-1:0] link_up;
  logic [NUM_LINKS-1:0] learned;
  logic [47:0] peer_addr  [NUM_LINKS];
  logic [47:0] own_addr   [NUM_LINKS];
  logic [12:0] own_mep    [NUM_LINKS];
  logic [15:0] peer_mep   [NUM_LINKS];
  logic [31:0] last_seen  [NUM_LINKS];
  logic [3:0]  fail_count [NUM_LINKS];
  logic [3:0]  good_count [NUM_LINKS];
  logic [31:0] seq_count  [NUM_LINKS];

  logic [LW-1:0] idx;
  logic          v;
  logic          up_n;
  logic          lrn_n;
  logic [47:0]   peer_n;
  logic [15:0]   pmep_n;
  logic [31:0]   seen_n;
  logic [3:0]    fail_n;
  logic [3:0]    good_n;
  logic [31:0]   seq_n;
  logic          old_up;
  logic [31:0]   elapsed;
  logic [3:0]    cls;
  logic          tx_v;
  logic [47:0]   tx_dst;
  logic [31:0]   tx_sq;
  logic [12:0]   tx_mep;
  logic          fire;
  logic [ccm_pkg::OUT_W-1:0] res;

  assign idx     = LW'(q_item.link);
  assign v       = q_item.link_ok && link_valid[idx];
  assign q_ready = !out_valid || out_ready;
  assign fire    = q_valid && q_ready;
  assign elapsed = q_item.now_ms - last_seen[idx];

  always_comb begin
    up_n   = link_up[idx];
    lrn_n  = learned[idx];
    peer_n = peer_addr[idx];
    pmep_n = peer_mep[idx];
    seen_n = last_seen[idx];
    fail_n = fail_count[idx];
    good_n = good_count[idx];
    seq_n  = seq_count[idx];
    old_up = link_up[idx];
    cls    = ccm_pkg::CLS_NONE;
    tx_v   = 1'b0;
    tx_dst = 48'd0;
    tx_sq  = 32'd0;
    tx_mep = 13'd0;
    case (q_item.kind)
      ccm_pkg::KIND_INIT: begin
        old_up = 1'b1;
        up_n   = 1'b1;
        seen_n = q_item.now_ms;
        seq_n  = 32'd0;
        fail_n = 4'd0;
        if (q_item.mac != 48'd0) begin
          peer_n = q_item.mac;
          pmep_n = {3'd0, ccm_pkg::mep_hash(q_item.mac)};
          lrn_n  = 1'b1;
          good_n = cfg.up_confirm;
        end else begin
          peer_n = 48'd0;
          pmep_n = 16'd0;
          lrn_n  = 1'b0;
          good_n = 4'd0;
        end
      end
      ccm_pkg::KIND_FRAME: begin
        if (q_item.pre_class != ccm_pkg::CLS_NONE) begin
          cls = q_item.pre_class;
        end else if (q_item.mac == own_addr[idx]) begin
          cls = ccm_pkg::CLS_OWN;
        end else if (!learned[idx] || q_item.mac != peer_addr[idx]) begin
          cls    = learned[idx] ? ccm_pkg::CLS_CHANGE : ccm_pkg::CLS_LEARN;
          peer_n = q_item.mac;
          pmep_n = q_item.mep_id;
          lrn_n  = 1'b1;
          up_n   = 1'b1;
          seen_n = q_item.now_ms;
          fail_n = 4'd0;
          good_n = cfg.up_confirm;
        end else if (q_item.mep_id == peer_mep[idx]) begin
          cls    = ccm_pkg::CLS_MATCH;
          seen_n = q_item.now_ms;
          fail_n = 4'd0;
          if (good_n < cfg.up_confirm) good_n = good_n + 4'd1;
          if (good_n >= cfg.up_confirm) up_n = 1'b1;
        end else begin
          cls = ccm_pkg::CLS_MEPMISS;
        end
      end
      ccm_pkg::KIND_TICK: begin
        tx_v   = 1'b1;
        tx_dst = learned[idx] ? peer_addr[idx] : cfg.group_mac;
        tx_sq  = seq_count[idx];
        tx_mep = own_mep[idx];
        seq_n  = seq_count[idx] + 32'd1;
        if (learned[idx]) begin
          if (elapsed > {16'd0, cfg.ccm_timeout_ms}) begin
            if (fail_n < ccm_pkg::COUNT_MAX) fail_n = fail_n + 4'd1;
            good_n = 4'd0;
            if (fail_n >= cfg.down_confirm) up_n = 1'b0;
          end else begin
            fail_n = 4'd0;
            if (good_n < cfg.up_confirm) good_n = good_n + 4'd1;
            if (good_n >= cfg.up_confirm) up_n = 1'b1;
          end
        end else begin
          up_n = !(elapsed > {16'd0, cfg.startup_timeout_ms});
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res = '0;
    res[2:0] = q_item.link;
    if (!q_item.link_ok ||
        (q_item.kind != ccm_pkg::KIND_INIT && q_item.kind != ccm_pkg::KIND_SPARE && !v)) begin
      res[8:5] = ccm_pkg::CLS_UNKNOWN;
    end else begin
      res[3]       = up_n;
      res[4]       = up_n != old_up;
      res[8:5]     = cls;
      res[9]       = tx_v;
      res[57:10]   = tx_dst;
      res[89:58]   = tx_sq;
      res[102:90]  = tx_mep;
      res[150:103] = lrn_n ? peer_n : 48'd0;
      res[151]     = lrn_n;
    end
  end

  logic apply;
  assign apply = fire && q_item.link_ok &&
                 (q_item.kind == ccm_pkg::KIND_INIT ||
                  ((q_item.kind == ccm_pkg::KIND_FRAME || q_item.kind == ccm_pkg::KIND_TICK) && v));

  always_ff @(posedge clk) begin
    if (fire) out_data <= res;
    if (apply) begin
      peer_addr[idx]  <= peer_n;
      peer_mep[idx]   <= pmep_n;
      last_seen[idx]  <= seen_n;
      fail_count[idx] <= fail_n;
      good_count[idx] <= good_n;
      seq_count[idx]  <= seq_n;
      if (q_item.kind == ccm_pkg::KIND_INIT) begin
        own_addr[idx] <= q_item.self_addr;
        own_mep[idx]  <= ccm_pkg::mep_hash(q_item.self_addr);
      end
    end
    if (rst) begin
      out_valid  <= 1'b0;
      link_valid <= '0;
      link_up    <= '0;
      learned    <= '0;
    end else begin
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (apply) begin
        link_up[idx] <= up_n;
        learned[idx] <= lrn_n;
        if (q_item.kind == ccm_pkg::KIND_INIT) link_valid[idx] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/ccm_link_continuity_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  s_axis_tdata (248 bits)
// m_axis   out  m_axis_tvalid/m_axis_tready  m_axis_tdata (152 bits)
// cfg      in   cfg_we                       cfg_index, cfg_wdata
// front classifies header fields and queues up to two items
// back reads/writes per-link registers, one item per cycle unless stalled
// queue slot, then output register; one item per cycle unless stalled
// rst clears link valid, up and learned flags at once, no clearing pass
// m_axis stall backs up through the queue into s_axis_tready
module ccm_link_continuity_monitor #(
  parameter int NUM_LINKS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // kind, link, now_ms, frame_len, ether_type, level_byte, opcode, src_mac,
  // mep_id, self_addr, nbr_cfg
  input  wire logic [247:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_link, is_up, changed, rx_class, tx_valid, tx_dst_mac, tx_seq,
  // tx_mep_id, nbr_addr, peer_known
  output logic [151:0]      m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_wdata
);

  ccm_pkg::cfg_t  cfg;
  ccm_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ccm_timeout_ms     <= 16'd350;
      cfg.startup_timeout_ms <= 16'd1000;
      cfg.down_confirm       <= 4'd2;
      cfg.up_confirm         <= 4'd3;
      cfg.md_level           <= 3'd5;
      cfg.cfm_ether_type     <= 16'h8902;
      cfg.ccm_opcode         <= 8'd1;
      cfg.group_mac          <= 48'h0180C2000035;
    end else if (cfg_we) begin
      case (cfg_index)
        ccm_pkg::REG_CCM_TIMEOUT: cfg.ccm_timeout_ms     <= cfg_wdata[15:0];
        ccm_pkg::REG_STARTUP:     cfg.startup_timeout_ms <= cfg_wdata[15:0];
        ccm_pkg::REG_DOWN_CONF:   cfg.down_confirm       <= cfg_wdata[3:0];
        ccm_pkg::REG_UP_CONF:     cfg.up_confirm         <= cfg_wdata[3:0];
        ccm_pkg::REG_MD_LEVEL:    cfg.md_level           <= cfg_wdata[2:0];
        ccm_pkg::REG_ETHER_TYPE:  cfg.cfm_ether_type     <= cfg_wdata[15:0];
        ccm_pkg::REG_OPCODE:      cfg.ccm_opcode         <= cfg_wdata[7:0];
        ccm_pkg::REG_GROUP_MAC:   cfg.group_mac          <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ccm_front #(.NUM_LINKS(NUM_LINKS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ccm_back #(.NUM_LINKS(NUM_LINKS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  a_unknown_down: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8:5] == ccm_pkg::CLS_UNKNOWN |-> !m_axis_tdata[3])
    else $error("unknown link reported up");
  a_tx_only_tick: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8:5] == ccm_pkg::CLS_NONE)
    else $error("ccm sent on non-tick");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

endmodule
`default_nettype wire
